// File: sv/ptw_pkg.sv
// shared constants, codes and control structs of the page table walker
`default_nettype none
package ptw_pkg;

	localparam int TABLE_SLOTS       = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
	localparam int SLOT_W            = $clog2(TABLE_SLOTS);
	localparam int ADDR_W            = SLOT_W + IDX_W;
	localparam int CNT_W             = $clog2(TABLE_SLOTS + 1);
	localparam int STORE_DEPTH       = TABLE_SLOTS * ENTRIES_PER_TABLE;
	localparam int ENTRY_W           = 64;
	localparam logic [39:0] BASE_RESET = 40'd256;

	typedef enum logic [1:0] {
		MODE_MAP   = 2'd0,
		MODE_UNMAP = 2'd1,
		MODE_SET   = 2'd2,
		MODE_CHECK = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_UNALIGNED_VA = 4'd1,
		ST_UNALIGNED_PA = 4'd2,
		ST_WX           = 4'd3,
		ST_MAPPED       = 4'd4,
		ST_POOL_FULL    = 4'd5,
		ST_NOT_MAPPED   = 4'd6,
		ST_RANGE        = 4'd7,
		ST_INACCESSIBLE = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_FRONT, S_RD, S_DEC, S_ALLOC, S_WRITE, S_DONE
	} state_t;

	typedef struct packed {
		logic    clr_step;
		logic    capture;
		logic    start_walk;
		logic    rd_en;
		logic    descend;
		logic    alloc;
		logic    wr_leaf;
		logic    next_page;
		logic    set_st;
		status_t st_code;
		logic    load_out;
	} ptw_cmd_t;

	typedef struct packed {
		logic       clr_last;
		mode_t      mode;
		logic       va_unal;
		logic       pa_unal;
		logic       wx;
		logic       len_zero;
		logic       range_bad;
		logic [1:0] level;
		logic       present;
		logic       decode_ok;
		logic       room;
		logic       leaf_ok;
		logic       last_page;
		logic       out_busy;
	} ptw_stat_t;

	function automatic logic [IDX_W-1:0] level_idx(input logic [35:0] pg,
		input logic [1:0] lvl);
		logic [IDX_W-1:0] r;
		case (lvl)
			2'd3: r = pg[35:27];
			2'd2: r = pg[26:18];
			2'd1: r = pg[17:9];
			default: r = pg[8:0];
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/ptw_if.sv
// request, response and configuration channel interfaces
`default_nettype none
interface ptw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] virt_addr;
	logic [51:0] phys_addr;
	logic [11:0] flag_bits;
	logic        no_execute;
	logic [31:0] length;
	logic        check_writable;
	modport source (output valid, mode, virt_addr, phys_addr, flag_bits, no_execute,
		length, check_writable, input ready);
	modport sink (input valid, mode, virt_addr, phys_addr, flag_bits, no_execute,
		length, check_writable, output ready);
endinterface

interface ptw_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic        tlb_invalidate;
	logic [47:0] invalidate_addr;
	logic [4:0]  tables_used;
	logic [31:0] installed_count;
	logic [31:0] removed_count;
	modport source (output valid, status, tlb_invalidate, invalidate_addr, tables_used,
		installed_count, removed_count, input ready);
	modport sink (input valid, status, tlb_invalidate, invalidate_addr, tables_used,
		installed_count, removed_count, output ready);
endinterface

interface ptw_cfg_if;
	logic        valid;
	logic        ready;
	logic [39:0] pool_base_frame;
	modport source (output valid, pool_base_frame, input ready);
	modport sink (input valid, pool_base_frame, output ready);
endinterface
`default_nettype wire

// File: sv/page_table_map_walker.sv
// top level of the four-level page table walker
//  channel | dir | transfer when          | payload
//  req     | in  | req.valid & req.ready  | mode, addresses, flags, length
//  rsp     | out | rsp.valid & rsp.ready  | status, invalidate, counters
//  cfg     | in  | cfg.valid & cfg.ready  | pool_base_frame
// one request at a time; each walk level is a store read (S_RD) followed by a decode (S_DEC)
// range check: walks every page touched; a request refused up front skips the walk
// after reset the whole table store is cleared before req.ready rises
// a finished result waits in the output register; the next request is taken meanwhile
// a result still waiting when the next one is done holds the walker until rsp transfers
`default_nettype none
module page_table_map_walker (
	input wire logic  clk,
	input wire logic  arst_n,
	ptw_req_if.sink   req,
	ptw_rsp_if.source rsp,
	ptw_cfg_if.sink   cfg
);
	import ptw_pkg::*;

	ptw_cmd_t  cmd;
	ptw_stat_t st;
	state_t    state;

	ptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd),
		.state     (state)
	);

	ptw_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.st     (st)
	);

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.tables_used != 5'd0 && rsp.tables_used <= 5'(TABLE_SLOTS)))
		else $error("tables_used out of range");

	a_inv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.tlb_invalidate) |-> (rsp.status == ST_OK))
		else $error("invalidate without ok status");

	a_no_inv_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.tlb_invalidate) |-> (rsp.invalidate_addr == 48'd0))
		else $error("invalidate address without invalidate");

	a_alloc_only_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> (st.mode == MODE_MAP && state == S_ALLOC))
		else $error("table allocated outside map");
endmodule
`default_nettype wire

// File: sv/ptw_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/ptw_ctrl.sv
// walker controller state machine
`default_nettype none
module ptw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire ptw_pkg::ptw_stat_t st,
	output ptw_pkg::ptw_cmd_t       cmd,
	output ptw_pkg::state_t         state
);
	import ptw_pkg::*;

	state_t state_q, state_d;

	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.st_code = ST_OK;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_FRONT;
				end
			end
			S_FRONT: begin
				state_d = S_DONE;
				cmd.set_st = 1'b1;
				case (st.mode)
					MODE_MAP: begin
						if (st.va_unal) cmd.st_code = ST_UNALIGNED_VA;
						else if (st.pa_unal) cmd.st_code = ST_UNALIGNED_PA;
						else if (st.wx) cmd.st_code = ST_WX;
						else begin
							cmd.set_st = 1'b0;
							cmd.start_walk = 1'b1;
							state_d = S_RD;
						end
					end
					MODE_CHECK: begin
						if (st.len_zero) cmd.st_code = ST_OK;
						else if (st.range_bad) cmd.st_code = ST_RANGE;
						else begin
							cmd.set_st = 1'b0;
							cmd.start_walk = 1'b1;
							state_d = S_RD;
						end
					end
					default: begin
						if (st.va_unal) cmd.st_code = ST_UNALIGNED_VA;
						else begin
							cmd.set_st = 1'b0;
							cmd.start_walk = 1'b1;
							state_d = S_RD;
						end
					end
				endcase
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_DONE;
				cmd.set_st = 1'b1;
				if (st.level != 2'd0) begin
					if (!st.present) begin
						case (st.mode)
							MODE_MAP: begin
								if (st.room) begin
									cmd.set_st = 1'b0;
									state_d = S_ALLOC;
								end else begin
									cmd.st_code = ST_POOL_FULL;
								end
							end
							MODE_UNMAP: cmd.st_code = ST_OK;
							MODE_SET:   cmd.st_code = ST_NOT_MAPPED;
							default:    cmd.st_code = ST_INACCESSIBLE;
						endcase
					end else if (!st.decode_ok) begin
						case (st.mode)
							MODE_UNMAP: cmd.st_code = ST_OK;
							MODE_CHECK: cmd.st_code = ST_INACCESSIBLE;
							default:    cmd.st_code = ST_NOT_MAPPED;
						endcase
					end else begin
						cmd.set_st = 1'b0;
						cmd.descend = 1'b1;
						state_d = S_RD;
					end
				end else begin
					case (st.mode)
						MODE_MAP: begin
							if (st.present) cmd.st_code = ST_MAPPED;
							else begin
								cmd.set_st = 1'b0;
								state_d = S_WRITE;
							end
						end
						MODE_UNMAP: begin
							if (st.present) begin
								cmd.set_st = 1'b0;
								state_d = S_WRITE;
							end else begin
								cmd.st_code = ST_OK;
							end
						end
						MODE_SET: begin
							if (st.present) begin
								cmd.set_st = 1'b0;
								state_d = S_WRITE;
							end else begin
								cmd.st_code = ST_NOT_MAPPED;
							end
						end
						default: begin
							if (!st.leaf_ok) cmd.st_code = ST_INACCESSIBLE;
							else if (st.last_page) cmd.st_code = ST_OK;
							else begin
								cmd.set_st = 1'b0;
								cmd.next_page = 1'b1;
								state_d = S_RD;
							end
						end
					endcase
				end
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				if (st.level == 2'd1) state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.wr_leaf = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/ptw_dp.sv
// walker datapath: item registers, walk registers, table store and result register
`default_nettype none
module ptw_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ptw_req_if.sink                req,
	ptw_rsp_if.source              rsp,
	ptw_cfg_if.sink                cfg,
	input  wire ptw_pkg::ptw_cmd_t cmd,
	output ptw_pkg::ptw_stat_t     st
);
	import ptw_pkg::*;

	logic [39:0]        base_q;
	mode_t              mode_q;
	logic [63:0]        va_q;
	logic [51:0]        pa_q;
	logic [11:0]        flags_q;
	logic               nx_q;
	logic [31:0]        len_q;
	logic               need_w_q;
	logic [35:0]        page_q;
	logic [34:0]        last_q;
	logic [1:0]         level_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   used_q;
	logic [31:0]        made_q;
	logic [31:0]        dropped_q;
	logic [ADDR_W-1:0]  clr_q;
	status_t            st_q;
	logic               inv_q;
	logic               out_valid_q;

	logic [ENTRY_W-1:0] rdata;
	logic [47:0]        range_end;
	logic [39:0]        diff;
	logic [39:0]        fresh_frame;
	logic [ADDR_W-1:0]  walk_addr;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [2:0]         need;

	assign cfg.ready   = 1'b1;
	assign range_end   = {1'b0, va_q[46:0]} + 48'(len_q) - 48'd1;
	assign diff        = rdata[51:12] - base_q;
	assign fresh_frame = base_q + 40'(used_q);
	assign walk_addr   = {slot_q, level_idx(page_q, level_q)};
	assign need        = {1'b1, need_w_q, 1'b1};

	always_comb begin
		we    = cmd.clr_step | cmd.alloc | cmd.wr_leaf;
		waddr = cmd.clr_step ? clr_q : walk_addr;
		wdata = '0;
		if (cmd.alloc) begin
			wdata = {12'h000, fresh_frame, 10'h000, 2'b11};
		end else if (cmd.wr_leaf) begin
			case (mode_q)
				MODE_MAP: wdata = {nx_q, 11'h000, pa_q[51:12], flags_q | 12'h001};
				MODE_SET: wdata = {nx_q, 11'h000, rdata[51:12], flags_q | 12'h001};
				default:  wdata = '0;
			endcase
		end
	end

	ptw_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (walk_addr),
		.rdata (rdata)
	);

	always_comb begin
		st.clr_last  = (clr_q == ADDR_W'(STORE_DEPTH - 1));
		st.mode      = mode_q;
		st.va_unal   = (va_q[11:0] != 12'h000);
		st.pa_unal   = (pa_q[11:0] != 12'h000);
		st.wx        = flags_q[1] & ~nx_q;
		st.len_zero  = (len_q == 32'd0);
		st.range_bad = (va_q[63:47] != 17'd0) | range_end[47];
		st.level     = level_q;
		st.present   = rdata[0];
		st.decode_ok = (diff[39:SLOT_W] == '0) && (CNT_W'(diff[SLOT_W-1:0]) < used_q);
		st.room      = (({1'b0, used_q} + (CNT_W+1)'(level_q))
			<= (CNT_W+1)'(TABLE_SLOTS));
		st.leaf_ok   = ((rdata[2:0] & need) == need);
		st.last_page = (page_q[34:0] == last_q);
		st.out_busy  = out_valid_q & ~rsp.ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RESET;
			used_q      <= CNT_W'(1);
			made_q      <= '0;
			dropped_q   <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) base_q <= cfg.pool_base_frame;
			if (cmd.clr_step) clr_q <= clr_q + ADDR_W'(1);
			if (cmd.alloc) used_q <= used_q + CNT_W'(1);
			if (cmd.wr_leaf && mode_q == MODE_MAP) made_q <= made_q + 32'd1;
			if (cmd.wr_leaf && mode_q == MODE_UNMAP) dropped_q <= dropped_q + 32'd1;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// item, walk and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode_t'(req.mode);
			va_q     <= req.virt_addr;
			pa_q     <= req.phys_addr;
			flags_q  <= req.flag_bits;
			nx_q     <= req.no_execute;
			len_q    <= req.length;
			need_w_q <= req.check_writable;
			page_q   <= req.virt_addr[47:12];
		end
		if (cmd.start_walk) begin
			last_q <= range_end[46:12];
		end
		if (cmd.start_walk || cmd.next_page) begin
			level_q <= 2'd3;
			slot_q  <= '0;
		end
		if (cmd.next_page) page_q <= page_q + 36'd1;
		if (cmd.descend) begin
			level_q <= level_q - 2'd1;
			slot_q  <= diff[SLOT_W-1:0];
		end
		if (cmd.alloc) begin
			level_q <= level_q - 2'd1;
			slot_q  <= used_q[SLOT_W-1:0];
		end
		if (cmd.set_st) begin
			st_q  <= cmd.st_code;
			inv_q <= 1'b0;
		end
		if (cmd.wr_leaf) begin
			st_q  <= ST_OK;
			inv_q <= 1'b1;
		end
		if (cmd.load_out) begin
			rsp.status          <= st_q;
			rsp.tlb_invalidate  <= inv_q;
			rsp.invalidate_addr <= inv_q ? va_q[47:0] : 48'd0;
			rsp.tables_used     <= 5'(used_q);
			rsp.installed_count <= made_q;
			rsp.removed_count   <= dropped_q;
		end
	end

	assign rsp.valid = out_valid_q;
endmodule
`default_nettype wire
